// ===== rtl/core/rtcu_pkg.sv =====
// Shared types, register codes and mode-word masks for the root counter timer unit.
package rtcu_pkg;

	localparam int NUM_TIMERS_DEF = 3;
	localparam int PIXEL_DIV_DEF  = 5;
	localparam int EIGHTH_DIV_DEF = 8;

	localparam int CNT_W   = 16;
	localparam int PRE_W   = 12;
	localparam int IRQ_W   = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [PRE_W-1:0] HSYNC_DIV_RESET = 12'd2146;
	localparam int HALVE_TIMER = 2;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_WRITE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REG_COUNT  = 2'd0,
		REG_MODE   = 2'd1,
		REG_TARGET = 2'd2
	} reg_sel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HSYNC_DIV = 2'd0,
		CFG_HALVE_RD  = 2'd1
	} cfg_idx_t;

	localparam logic [CNT_W-1:0] M_STOP       = 16'h0001;
	localparam logic [CNT_W-1:0] M_TO_TARGET  = 16'h0008;
	localparam logic [CNT_W-1:0] M_IRQ_TARGET = 16'h0010;
	localparam logic [CNT_W-1:0] M_IRQ_OVF    = 16'h0020;
	localparam logic [CNT_W-1:0] M_REGEN      = 16'h0040;
	localparam logic [CNT_W-1:0] M_CLK_A      = 16'h0100;
	localparam logic [CNT_W-1:0] M_CLK_B      = 16'h0200;
	localparam logic [CNT_W-1:0] M_IRQREQ     = 16'h0400;
	localparam logic [CNT_W-1:0] M_HIT_TARGET = 16'h0800;
	localparam logic [CNT_W-1:0] M_HIT_OVF    = 16'h1000;
	localparam logic [CNT_W-1:0] M_READ_CLEAR = 16'he7ff;

	// One timer's share of the current beat.
	typedef struct packed {
		logic             tick;
		logic             access;
		logic             is_write;
		logic [1:0]       reg_sel;
		logic [CNT_W-1:0] data;
	} tmr_cmd_t;

endpackage

// ===== rtl/core/rtcu_timer.sv =====
// One 16-bit timer: prescaler, count, target compare, status flags and irq logic.
module rtcu_timer #(
	parameter int TIMER_ID   = 0,
	parameter int PIXEL_DIV  = rtcu_pkg::PIXEL_DIV_DEF,
	parameter int EIGHTH_DIV = rtcu_pkg::EIGHTH_DIV_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rtcu_pkg::tmr_cmd_t             cmd,
	input  logic [rtcu_pkg::PRE_W-1:0]     hsync_div,
	input  logic                           halve_rd,
	output logic [rtcu_pkg::CNT_W-1:0]     rd_data,
	output logic                           irq
);

	localparam int CW = rtcu_pkg::CNT_W;
	localparam int PW = rtcu_pkg::PRE_W;

	logic [CW-1:0] count_q, mode_q, target_q;
	logic [PW-1:0] pre_q;
	logic          fired_q, heading_q;

	logic [CW-1:0] count_d, mode_d, target_d;
	logic [PW-1:0] pre_d;
	logic          fired_d, heading_d;

	logic [PW-1:0] rate;
	logic [PW:0]   pre_inc;
	logic [CW:0]   next_cnt;
	logic          hit_target;

	// Prescale rate; zero means stopped
	always_comb begin
		rate = PW'(1);
		if (TIMER_ID == 0) begin
			if ((mode_q & rtcu_pkg::M_CLK_A) != '0)
				rate = PW'(PIXEL_DIV);
		end else if (TIMER_ID == 1) begin
			if ((mode_q & rtcu_pkg::M_CLK_A) != '0)
				rate = (hsync_div == '0) ? PW'(1) : hsync_div;
		end else begin
			if ((mode_q & rtcu_pkg::M_STOP) != '0)
				rate = '0;
			else if ((mode_q & rtcu_pkg::M_CLK_B) != '0)
				rate = PW'(EIGHTH_DIV);
		end
	end

	assign pre_inc    = {1'b0, pre_q} + (PW+1)'(1);
	assign next_cnt   = {1'b0, count_q} + (CW+1)'(1);
	assign hit_target = heading_q && (next_cnt == {1'b0, target_q});

	// Read value
	always_comb begin
		case (cmd.reg_sel)
			rtcu_pkg::REG_COUNT: begin
				rd_data = count_q;
				if (halve_rd && TIMER_ID == rtcu_pkg::HALVE_TIMER && heading_q)
					rd_data = count_q >> 1;
			end
			rtcu_pkg::REG_MODE:   rd_data = mode_q;
			rtcu_pkg::REG_TARGET: rd_data = target_q;
			default:              rd_data = '0;
		endcase
	end

	always_comb begin
		count_d   = count_q;
		mode_d    = mode_q;
		target_d  = target_q;
		pre_d     = pre_q;
		fired_d   = fired_q;
		heading_d = heading_q;
		irq       = 1'b0;
		if (cmd.tick && rate != '0) begin
			if (pre_inc < {1'b0, rate}) begin
				pre_d = pre_inc[PW-1:0];
			end else begin
				pre_d   = '0;
				count_d = next_cnt[CW-1:0];
				if (hit_target) begin
					mode_d = mode_q | rtcu_pkg::M_IRQREQ | rtcu_pkg::M_HIT_TARGET;
					if ((mode_q & rtcu_pkg::M_TO_TARGET) != '0)
						count_d = '0;
					else
						heading_d = 1'b0;
					if ((mode_q & rtcu_pkg::M_IRQ_TARGET) != '0 &&
					    ((mode_q & rtcu_pkg::M_REGEN) != '0 || !fired_q)) begin
						irq     = 1'b1;
						fired_d = 1'b1;
					end
				end else if (next_cnt[CW]) begin
					mode_d  = mode_q | rtcu_pkg::M_IRQREQ | rtcu_pkg::M_HIT_OVF;
					count_d = '0;
					if (target_q != '0)
						heading_d = 1'b1;
					if ((mode_q & rtcu_pkg::M_IRQ_OVF) != '0 &&
					    ((mode_q & rtcu_pkg::M_REGEN) != '0 || !fired_q)) begin
						irq     = 1'b1;
						fired_d = 1'b1;
					end
				end
			end
		end else if (cmd.access && !cmd.is_write) begin
			// Reading mode acknowledges the hit flags
			if (cmd.reg_sel == rtcu_pkg::REG_MODE)
				mode_d = mode_q & rtcu_pkg::M_READ_CLEAR;
		end else if (cmd.access && cmd.is_write) begin
			case (cmd.reg_sel)
				rtcu_pkg::REG_COUNT: begin
					count_d   = cmd.data;
					pre_d     = '0;
					heading_d = cmd.data < target_q;
				end
				rtcu_pkg::REG_MODE: begin
					mode_d    = cmd.data;
					count_d   = '0;
					pre_d     = '0;
					fired_d   = 1'b0;
					heading_d = target_q != '0;
				end
				rtcu_pkg::REG_TARGET: begin
					target_d  = cmd.data;
					pre_d     = '0;
					heading_d = count_q < cmd.data;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			mode_q    <= '0;
			target_q  <= '0;
			pre_q     <= '0;
			fired_q   <= 1'b0;
			heading_q <= 1'b0;
		end else begin
			count_q   <= count_d;
			mode_q    <= mode_d;
			target_q  <= target_d;
			pre_q     <= pre_d;
			fired_q   <= fired_d;
			heading_q <= heading_d;
		end
	end

endmodule

// ===== rtl/core/triple_root_counter_timer_unit.sv =====
// Top level of the three-timer root counter unit with stream and config ports.
// One beat in, one beat out, one beat per clock sustained while m_axis_tready is
// high. A beat (tick, register read or register write) is captured in the input
// register, worked in a single pass by the per-timer next-state logic, and lands
// in the result register, which drives the master side, once that register is
// free or being drained. The input
// register keeps taking beats while a result waits for m_axis_tready, until both
// registers are full. The config port takes a write every cycle (cfg_ready is
// tied high); change it only while no beat is in flight. Register index 0 holds
// the hsync divider (12 bits, zero acts as one), index 1 the halved count read
// enable for timer 2; other indexes are dropped.
module triple_root_counter_timer_unit #(
	parameter int NUM_TIMERS = rtcu_pkg::NUM_TIMERS_DEF,
	parameter int PIXEL_DIV  = rtcu_pkg::PIXEL_DIV_DEF,
	parameter int EIGHTH_DIV = rtcu_pkg::EIGHTH_DIV_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [15:0]                       s_axis_tdata,  // write_data[15:0]
	input  logic [5:0]                        s_axis_tuser,  // kind[1:0], timer_select[3:2],
	                                                         // reg_select[5:4]
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [23:0]                       m_axis_tdata,  // read_data[15:0],
	                                                         // irq_pulses[18:16], zeros
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rtcu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rtcu_pkg::PRE_W-1:0]        cfg_data
);

	localparam int CW = rtcu_pkg::CNT_W;

	// Input register
	logic          valid_s1;
	logic [1:0]    kind_s1, tsel_s1, rsel_s1;
	logic [CW-1:0] data_s1;

	// Result register
	logic                        out_valid_q;
	logic [CW-1:0]               rd_q;
	logic [rtcu_pkg::IRQ_W-1:0]  irq_q;

	logic [rtcu_pkg::PRE_W-1:0]  hsync_q;
	logic                        halve_q;

	logic                        advance;
	logic                        in_beat;
	rtcu_pkg::tmr_cmd_t          cmd   [NUM_TIMERS];
	logic [CW-1:0]               rd_arr[NUM_TIMERS];
	logic [NUM_TIMERS-1:0]       irq_arr;
	logic [CW-1:0]               rd_mux;
	logic [rtcu_pkg::IRQ_W-1:0]  irq_mux;

	// Work the held beat whenever the result register is free or being drained
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, irq_q, rd_q};
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			kind_s1 <= s_axis_tuser[1:0];
			tsel_s1 <= s_axis_tuser[3:2];
			rsel_s1 <= s_axis_tuser[5:4];
			data_s1 <= s_axis_tdata;
		end
	end

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsync_q <= rtcu_pkg::HSYNC_DIV_RESET;
			halve_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				rtcu_pkg::CFG_HSYNC_DIV: hsync_q <= cfg_data;
				rtcu_pkg::CFG_HALVE_RD:  halve_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Fan the beat out to the timers; a tick goes to all, an access to one
	genvar gi;
	generate
		for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_tmr
			always_comb begin
				cmd[gi].tick     = advance && (kind_s1 == rtcu_pkg::KIND_TICK);
				cmd[gi].access   = advance && (tsel_s1 == 2'(gi)) &&
				                   (kind_s1 == rtcu_pkg::KIND_READ ||
				                    kind_s1 == rtcu_pkg::KIND_WRITE);
				cmd[gi].is_write = (kind_s1 == rtcu_pkg::KIND_WRITE);
				cmd[gi].reg_sel  = rsel_s1;
				cmd[gi].data     = data_s1;
			end

			rtcu_timer #(
				.TIMER_ID   (gi),
				.PIXEL_DIV  (PIXEL_DIV),
				.EIGHTH_DIV (EIGHTH_DIV)
			) u_timer (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd[gi]),
				.hsync_div (hsync_q),
				.halve_rd  (halve_q),
				.rd_data   (rd_arr[gi]),
				.irq       (irq_arr[gi])
			);
		end
	endgenerate

	// Result: read data only for a read of an existing timer, irqs only on a tick
	always_comb begin
		rd_mux  = '0;
		irq_mux = '0;
		for (int i = 0; i < NUM_TIMERS; i++) begin
			if (kind_s1 == rtcu_pkg::KIND_READ && tsel_s1 == 2'(i))
				rd_mux = rd_arr[i];
			if (kind_s1 == rtcu_pkg::KIND_TICK)
				irq_mux[i] = irq_arr[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rd_q  <= rd_mux;
			irq_q <= irq_mux;
		end
	end

endmodule

// ===== rtl/core/rtcu_checker.sv =====
// Port-level checks for the root counter timer unit, bound to the top level.
module rtcu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [23:0] m_axis_tdata,
	input logic        cfg_ready
);

	// A stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// An empty result register never back-pressures the input
	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// A beat carries either read data or irq pulses, never both
	a_rd_irq_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[15:0] != 16'd0 |-> m_axis_tdata[18:16] == 3'd0)
		else $error("read data and irq in one beat");

	// Padding stays zero and config is always taken
	a_pad_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[23:19] == 5'd0 && cfg_ready)
		else $error("nonzero padding or config stalled");

endmodule

bind triple_root_counter_timer_unit rtcu_checker u_rtcu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_ready     (cfg_ready)
);
